// ===== rtl/qvr_pkg.sv =====
package qvr_pkg;

    // Field widths.
    localparam int VEC_WIDTH  = 32;
    localparam int QUAT_WIDTH = 16;

    // Internal widths derived from the field widths.
    localparam int PROD_WIDTH = 2 * QUAT_WIDTH;
    localparam int MAT_WIDTH  = PROD_WIDTH + 2;
    localparam int NORM_WIDTH = PROD_WIDTH + 1;
    localparam int LO_WIDTH   = VEC_WIDTH / 2;
    localparam int HI_WIDTH   = VEC_WIDTH - LO_WIDTH;
    localparam int TERM_WIDTH = MAT_WIDTH + VEC_WIDTH;
    localparam int SUM_WIDTH  = TERM_WIDTH + 2;

    // Number of quaternion products and matrix entries.
    localparam int NUM_PROD = 10;
    localparam int NUM_MAT  = 9;
    localparam int NUM_AXIS = 3;

    // Product indexes.
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_XY = 4;
    localparam int P_WZ = 5;
    localparam int P_XZ = 6;
    localparam int P_WY = 7;
    localparam int P_YZ = 8;
    localparam int P_WX = 9;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_w;
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
        logic signed [VEC_WIDTH-1:0]  vec_x;
        logic signed [VEC_WIDTH-1:0]  vec_y;
        logic signed [VEC_WIDTH-1:0]  vec_z;
    } t_in_item;

    typedef struct packed {
        logic signed [VEC_WIDTH-1:0] rot_x;
        logic signed [VEC_WIDTH-1:0] rot_y;
        logic signed [VEC_WIDTH-1:0] rot_z;
        logic                        zero_norm;
        logic                        saturated;
    } t_out_item;

    // Scaled rotation matrix, vector and norm.
    typedef struct packed {
        logic [NUM_MAT-1:0][MAT_WIDTH-1:0]  mat;
        logic [NUM_AXIS-1:0][VEC_WIDTH-1:0] vec;
        logic [NORM_WIDTH-1:0]              norm;
        logic                               zero;
    } t_mat;

    // Divider operands for the three components.
    typedef struct packed {
        logic [NUM_AXIS-1:0][NORM_WIDTH-1:0] rem;
        logic [NUM_AXIS-1:0][VEC_WIDTH-1:0]  low;
        logic [NUM_AXIS-1:0]                 neg;
        logic [NUM_AXIS-1:0]                 ovf;
        logic [NORM_WIDTH-1:0]               norm;
        logic                                zero;
    } t_div;

endpackage

// ===== rtl/qvr_matrix.sv =====
module qvr_matrix
    import qvr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_mat     o_mat
);

    localparam int STAGES = 2;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;

    logic [NUM_PROD-1:0][PROD_WIDTH-1:0] r_prod;
    logic [NUM_AXIS-1:0][VEC_WIDTH-1:0]  r_vec;
    t_mat                                r_mat;

    logic [NUM_PROD-1:0][PROD_WIDTH-1:0] n_prod;
    t_mat                                n_mat;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // The ten pairwise products of the quaternion parts.
    always_comb begin
        n_prod[P_WW] = PROD_WIDTH'(i_item.quat_w * i_item.quat_w);
        n_prod[P_XX] = PROD_WIDTH'(i_item.quat_x * i_item.quat_x);
        n_prod[P_YY] = PROD_WIDTH'(i_item.quat_y * i_item.quat_y);
        n_prod[P_ZZ] = PROD_WIDTH'(i_item.quat_z * i_item.quat_z);
        n_prod[P_XY] = PROD_WIDTH'(i_item.quat_x * i_item.quat_y);
        n_prod[P_WZ] = PROD_WIDTH'(i_item.quat_w * i_item.quat_z);
        n_prod[P_XZ] = PROD_WIDTH'(i_item.quat_x * i_item.quat_z);
        n_prod[P_WY] = PROD_WIDTH'(i_item.quat_w * i_item.quat_y);
        n_prod[P_YZ] = PROD_WIDTH'(i_item.quat_y * i_item.quat_z);
        n_prod[P_WX] = PROD_WIDTH'(i_item.quat_w * i_item.quat_x);
    end

    // Matrix equal to the norm times the rotation matrix, and the norm itself.
    always_comb begin
        logic signed [MAT_WIDTH-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
        ww = MAT_WIDTH'($signed(r_prod[P_WW]));
        xx = MAT_WIDTH'($signed(r_prod[P_XX]));
        yy = MAT_WIDTH'($signed(r_prod[P_YY]));
        zz = MAT_WIDTH'($signed(r_prod[P_ZZ]));
        xy = MAT_WIDTH'($signed(r_prod[P_XY]));
        wz = MAT_WIDTH'($signed(r_prod[P_WZ]));
        xz = MAT_WIDTH'($signed(r_prod[P_XZ]));
        wy = MAT_WIDTH'($signed(r_prod[P_WY]));
        yz = MAT_WIDTH'($signed(r_prod[P_YZ]));
        wx = MAT_WIDTH'($signed(r_prod[P_WX]));
        n_mat.mat[0] = ww + xx - yy - zz;
        n_mat.mat[1] = (xy - wz) <<< 1;
        n_mat.mat[2] = (xz + wy) <<< 1;
        n_mat.mat[3] = (xy + wz) <<< 1;
        n_mat.mat[4] = ww - xx + yy - zz;
        n_mat.mat[5] = (yz - wx) <<< 1;
        n_mat.mat[6] = (xz - wy) <<< 1;
        n_mat.mat[7] = (yz + wx) <<< 1;
        n_mat.mat[8] = ww - xx - yy + zz;
        n_mat.vec    = r_vec;
        n_mat.norm   = NORM_WIDTH'(r_prod[P_WW]) + NORM_WIDTH'(r_prod[P_XX])
                     + NORM_WIDTH'(r_prod[P_YY]) + NORM_WIDTH'(r_prod[P_ZZ]);
        n_mat.zero   = (r_prod[P_WW] == '0) && (r_prod[P_XX] == '0)
                     && (r_prod[P_YY] == '0) && (r_prod[P_ZZ] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_prod   <= n_prod;
            r_vec[0] <= i_item.vec_x;
            r_vec[1] <= i_item.vec_y;
            r_vec[2] <= i_item.vec_z;
        end
        if (en[1]) begin
            r_mat <= n_mat;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_mat   = r_mat;

endmodule

// ===== rtl/qvr_mac.sv =====
module qvr_mac
    import qvr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_mat i_mat,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_div
);

    localparam int STAGES = 5;
    localparam int LO_PROD_WIDTH = MAT_WIDTH + LO_WIDTH + 1;
    localparam int HI_PROD_WIDTH = MAT_WIDTH + HI_WIDTH;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;

    // Norm and zero flag follow the item through every stage.
    logic [STAGES-2:0][NORM_WIDTH-1:0] r_norm;
    logic [STAGES-2:0]                 r_zero;

    logic [NUM_MAT-1:0][LO_PROD_WIDTH-1:0] r_lo;
    logic [NUM_MAT-1:0][HI_PROD_WIDTH-1:0] r_hi;
    logic [NUM_MAT-1:0][TERM_WIDTH-1:0]    r_term;
    logic [NUM_AXIS-1:0][SUM_WIDTH-1:0]    r_sum;
    logic [NUM_AXIS-1:0][SUM_WIDTH-1:0]    r_mag;
    logic [NUM_AXIS-1:0]                   r_neg;
    t_div                                  r_div;

    logic [NUM_MAT-1:0][LO_PROD_WIDTH-1:0] n_lo;
    logic [NUM_MAT-1:0][HI_PROD_WIDTH-1:0] n_hi;
    logic [NUM_MAT-1:0][TERM_WIDTH-1:0]    n_term;
    logic [NUM_AXIS-1:0][SUM_WIDTH-1:0]    n_sum;
    logic [NUM_AXIS-1:0][SUM_WIDTH-1:0]    n_mag;
    logic [NUM_AXIS-1:0]                   n_neg;
    t_div                                  n_div;

    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Each vector part is split in two halves so that no multiplier grows too wide.
    always_comb begin
        for (int m = 0; m < NUM_MAT; m++) begin
            logic signed [MAT_WIDTH-1:0]     a;
            logic signed [LO_WIDTH:0]        vl;
            logic signed [HI_WIDTH-1:0]      vh;
            logic signed [LO_PROD_WIDTH-1:0] pl;
            logic signed [HI_PROD_WIDTH-1:0] ph;
            a  = $signed(i_mat.mat[m]);
            vl = $signed({1'b0, i_mat.vec[m % NUM_AXIS][LO_WIDTH-1:0]});
            vh = $signed(i_mat.vec[m % NUM_AXIS][VEC_WIDTH-1:LO_WIDTH]);
            pl = a * vl;
            ph = a * vh;
            n_lo[m] = pl;
            n_hi[m] = ph;
        end
    end

    // Join the halves into full matrix-times-vector terms.
    always_comb begin
        for (int m = 0; m < NUM_MAT; m++) begin
            logic signed [TERM_WIDTH-1:0] hs;
            logic signed [TERM_WIDTH-1:0] ls;
            hs = TERM_WIDTH'($signed(r_hi[m])) <<< LO_WIDTH;
            ls = TERM_WIDTH'($signed(r_lo[m]));
            n_term[m] = hs + ls;
        end
    end

    // Row sums, exact.
    always_comb begin
        for (int i = 0; i < NUM_AXIS; i++) begin
            n_sum[i] = SUM_WIDTH'($signed(r_term[NUM_AXIS*i]))
                     + SUM_WIDTH'($signed(r_term[NUM_AXIS*i+1]))
                     + SUM_WIDTH'($signed(r_term[NUM_AXIS*i+2]));
        end
    end

    // Sign and magnitude of each row sum.
    always_comb begin
        for (int i = 0; i < NUM_AXIS; i++) begin
            n_neg[i] = r_sum[i][SUM_WIDTH-1];
            n_mag[i] = n_neg[i] ? SUM_WIDTH'(-r_sum[i]) : r_sum[i];
        end
    end

    // A quotient of the full result width or more always saturates; otherwise
    // the upper magnitude bits seed the divider remainder.
    always_comb begin
        for (int i = 0; i < NUM_AXIS; i++) begin
            logic [SUM_WIDTH-1:0] bound;
            bound        = SUM_WIDTH'({r_norm[3], {VEC_WIDTH{1'b0}}});
            n_div.ovf[i] = r_mag[i] >= bound;
            n_div.rem[i] = n_div.ovf[i] ? '0
                         : NORM_WIDTH'(r_mag[i][SUM_WIDTH-1:VEC_WIDTH]);
            n_div.low[i] = r_mag[i][VEC_WIDTH-1:0];
        end
        n_div.neg  = r_neg;
        n_div.norm = r_norm[3];
        n_div.zero = r_zero[3];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_norm[0] <= i_mat.norm;
            r_zero[0] <= i_mat.zero;
        end
        if (en[1]) begin
            r_term    <= n_term;
            r_norm[1] <= r_norm[0];
            r_zero[1] <= r_zero[0];
        end
        if (en[2]) begin
            r_sum     <= n_sum;
            r_norm[2] <= r_norm[1];
            r_zero[2] <= r_zero[1];
        end
        if (en[3]) begin
            r_mag     <= n_mag;
            r_neg     <= n_neg;
            r_norm[3] <= r_norm[2];
            r_zero[3] <= r_zero[2];
        end
        if (en[4]) begin
            r_div <= n_div;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_div   = r_div;

endmodule

// ===== rtl/qvr_div.sv =====
module qvr_div
    import qvr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div      i_div,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    // One quotient bit per stage, then a rounding stage and an output stage.
    localparam int STEPS    = VEC_WIDTH;
    localparam int STAGES   = STEPS + 2;
    localparam int Q_WIDTH  = VEC_WIDTH + 1;
    localparam logic [Q_WIDTH-1:0] LIMIT = Q_WIDTH'(1) << (VEC_WIDTH - 1);

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;

    logic [STEPS-1:0][NUM_AXIS-1:0][NORM_WIDTH-1:0] r_rem;
    logic [STEPS-1:0][NUM_AXIS-1:0][VEC_WIDTH-1:0]  r_low;
    logic [STEPS-1:0][NUM_AXIS-1:0][VEC_WIDTH-1:0]  r_quo;
    logic [STEPS:0][NUM_AXIS-1:0]                   r_neg;
    logic [STEPS:0][NUM_AXIS-1:0]                   r_ovf;
    logic [STEPS-1:0][NORM_WIDTH-1:0]               r_norm;
    logic [STEPS:0]                                 r_zero;
    logic [NUM_AXIS-1:0][Q_WIDTH-1:0]               r_qr;
    t_out_item                                      r_out;

    logic [STEPS-1:0][NUM_AXIS-1:0][NORM_WIDTH-1:0] n_rem;
    logic [STEPS-1:0][NUM_AXIS-1:0][VEC_WIDTH-1:0]  n_low;
    logic [STEPS-1:0][NUM_AXIS-1:0][VEC_WIDTH-1:0]  n_quo;
    logic [NUM_AXIS-1:0][Q_WIDTH-1:0]               n_qr;
    t_out_item                                      n_out;

    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Restoring division steps: shift in the next numerator bit, subtract the
    // norm when it fits.
    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            for (int i = 0; i < NUM_AXIS; i++) begin
                logic [NORM_WIDTH-1:0] rem_in;
                logic [VEC_WIDTH-1:0]  low_in;
                logic [VEC_WIDTH-1:0]  quo_in;
                logic [NORM_WIDTH-1:0] norm_in;
                logic [NORM_WIDTH:0]   t;
                logic [NORM_WIDTH:0]   diff;
                logic                  ge;
                if (k == 0) begin
                    rem_in  = i_div.rem[i];
                    low_in  = i_div.low[i];
                    quo_in  = '0;
                    norm_in = i_div.norm;
                end else begin
                    rem_in  = r_rem[k-1][i];
                    low_in  = r_low[k-1][i];
                    quo_in  = r_quo[k-1][i];
                    norm_in = r_norm[k-1];
                end
                t    = {rem_in, low_in[VEC_WIDTH-1]};
                diff = t - {1'b0, norm_in};
                ge   = t >= {1'b0, norm_in};
                n_rem[k][i] = ge ? diff[NORM_WIDTH-1:0] : t[NORM_WIDTH-1:0];
                n_low[k][i] = low_in << 1;
                n_quo[k][i] = {quo_in[VEC_WIDTH-2:0], ge};
            end
        end
    end

    // Round to nearest, ties away from zero, on the magnitude.
    always_comb begin
        for (int i = 0; i < NUM_AXIS; i++) begin
            logic up;
            up = {r_rem[STEPS-1][i], 1'b0} >= {1'b0, r_norm[STEPS-1]};
            n_qr[i] = Q_WIDTH'(r_quo[STEPS-1][i]) + Q_WIDTH'(up);
        end
    end

    // Saturate, restore the sign and handle the zero quaternion.
    always_comb begin
        logic [NUM_AXIS-1:0][VEC_WIDTH-1:0] val;
        logic [NUM_AXIS-1:0]                sat;
        for (int i = 0; i < NUM_AXIS; i++) begin
            logic [Q_WIDTH-1:0] neg_q;
            neg_q = -r_qr[i];
            if (r_neg[STEPS][i]) begin
                sat[i] = r_ovf[STEPS][i] || (r_qr[i] > LIMIT);
                val[i] = sat[i] ? LIMIT[VEC_WIDTH-1:0] : neg_q[VEC_WIDTH-1:0];
            end else begin
                sat[i] = r_ovf[STEPS][i] || (r_qr[i] > LIMIT - 1'b1);
                val[i] = sat[i] ? VEC_WIDTH'(LIMIT - 1'b1) : r_qr[i][VEC_WIDTH-1:0];
            end
        end
        if (r_zero[STEPS]) begin
            n_out.rot_x     = '0;
            n_out.rot_y     = '0;
            n_out.rot_z     = '0;
            n_out.zero_norm = 1'b1;
            n_out.saturated = 1'b0;
        end else begin
            n_out.rot_x     = val[0];
            n_out.rot_y     = val[1];
            n_out.rot_z     = val[2];
            n_out.zero_norm = 1'b0;
            n_out.saturated = |sat;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STEPS; k++) begin
            if (en[k]) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                if (k == 0) begin
                    r_norm[k] <= i_div.norm;
                    r_neg[k]  <= i_div.neg;
                    r_ovf[k]  <= i_div.ovf;
                    r_zero[k] <= i_div.zero;
                end else begin
                    r_norm[k] <= r_norm[k-1];
                    r_neg[k]  <= r_neg[k-1];
                    r_ovf[k]  <= r_ovf[k-1];
                    r_zero[k] <= r_zero[k-1];
                end
            end
        end
        if (en[STEPS]) begin
            r_qr          <= n_qr;
            r_neg[STEPS]  <= r_neg[STEPS-1];
            r_ovf[STEPS]  <= r_ovf[STEPS-1];
            r_zero[STEPS] <= r_zero[STEPS-1];
        end
        if (en[STEPS+1]) begin
            r_out <= n_out;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_item  = r_out;

endmodule

// ===== rtl/quaternion_vector_rotate_unit.sv =====
// Rotates a Q16.16 vector by a Q1.14 quaternion as q * v * q^-1, with the
// inverse taken as conjugate over squared norm, so a non-unit quaternion still
// yields an exact rotation. The block takes one item per cycle unless the
// output stalls. Two stages build the scaled rotation matrix, five form the
// exact matrix-vector product, and the division by the norm runs through a
// restoring divider that produces one quotient bit per stage, followed by
// rounding (nearest, ties away from zero) and saturation. Stages hold their
// items on a stall and empty stages fill, so bubbles close up. A zero
// quaternion returns a zero vector with zero_norm set.
module quaternion_vector_rotate_unit
    import qvr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic mat_valid, mat_ready;
    logic div_valid, div_ready;
    logic in_ready;
    t_mat mat;
    t_div div;

    // Quaternion products and scaled rotation matrix.
    qvr_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (in_ready),
        .i_item  (i_in),
        .o_valid (mat_valid),
        .i_ready (mat_ready),
        .o_mat   (mat)
    );

    // Exact matrix-vector product, sign and magnitude.
    qvr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mat_valid),
        .o_ready (mat_ready),
        .i_mat   (mat),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_div   (div)
    );

    // Division by the norm, rounding and saturation.
    qvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_div   (div),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_item  (o_out)
    );

    assign o_in_stall = !in_ready;

endmodule
